/* src/tccw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the text console character writer.
// No dependencies; imported by every module of the block.
package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = COLUMNS * ROWS;

    // Field and storage widths
    localparam int CUR_W    = 11;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int OP_W     = 2;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);

    // Tab stops every TAB_STOP columns; a tab puts 1 to TAB_STOP blanks
    localparam int TAB_STOP = 8;
    localparam int TAB_BITS = $clog2(TAB_STOP);
    localparam int TAB_W    = TAB_BITS + 1;

    // Character and attribute codes
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;   // grey on black

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT        = 2'd0;
    localparam logic [OP_W-1:0] OP_READ       = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_CURSOR = 2'd2;

    // Input beat
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] char_code;
        logic [CUR_W-1:0]  cell_index;
    } t_item;

    // Result beat
    typedef struct packed {
        logic [CUR_W-1:0]  cursor_cell;
        logic [CHAR_W-1:0] read_char;
        logic [ATTR_W-1:0] read_attr;
        logic              scrolled;
    } t_result;

    // Write request into the screen store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_wr_req;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_DIV,
        ST_RD_DATA,
        ST_SCR_COPY,
        ST_SCR_DRAIN,
        ST_SCR_BLANK,
        ST_CUR_RD,
        ST_CUR_WR
    } t_state;

endpackage

/* src/text_console_char_writer.sv */
`timescale 1ns / 1ps
// Text console character writer: screen store, cursor and command sequencer.
// Depends on tccw_pkg and tccw_screen_ram.
// Set cursor finds the row by repeated subtraction of COLUMNS; a tab writes its blanks
// one cell at a time. A scroll copies the screen up one row through the single store
// port pair, then blanks the bottom row in the current attribute.
// Throughput: one command at a time; busy is high from accept until the result beat.
// Reset: synchronous; the store is swept to blanks with busy high.
module text_console_char_writer
    import tccw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_data,
    output logic              o_strobe,
    output t_result           o_result
);

    // Control registers
    t_state             r_state, n_state;
    logic [CUR_W-1:0]   r_cursor, n_cursor;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ATTR_W-1:0]  r_attr;
    logic [ADDR_W-1:0]  r_saddr, n_saddr;
    logic               r_wpend, n_wpend;
    logic               r_scrolled, n_scrolled;
    logic [TAB_W-1:0]   r_cnt, n_cnt;
    logic               r_back, n_back;
    logic               r_strobe;

    // Payload registers
    logic [CHAR_W-1:0]  r_char, n_char;
    logic [CHAR_W-1:0]  r_rchar, n_rchar;
    logic [ATTR_W-1:0]  r_rattr, n_rattr;
    logic               r_oor, n_oor;
    logic [ADDR_W-1:0]  r_waddr, n_waddr;
    logic [CUR_W-1:0]   r_divrem, n_divrem;
    t_result            r_res;

    // Store interface
    t_wr_req            w_wr;
    logic [ADDR_W-1:0]  w_raddr;
    logic [CELL_W-1:0]  w_rdata;

    // Helpers
    logic               w_accept;
    logic               w_col_last;
    logic               w_row_last;
    logic               w_put_wrap;
    logic [TAB_W-1:0]   w_cnt_dec;
    logic [TAB_W-1:0]   w_tab_n;
    logic [CUR_W-1:0]   w_idx_sat;
    logic               w_idx_oor;

    tccw_screen_ram u_screen_ram (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && (r_state == ST_IDLE);
    assign w_col_last = (r_col == COL_W'(COLUMNS - 1));
    assign w_row_last = (r_row == ROW_W'(ROWS - 1));
    assign w_put_wrap = !r_back && w_col_last && w_row_last;
    assign w_cnt_dec  = r_cnt - TAB_W'(1);
    assign w_tab_n    = TAB_W'(TAB_STOP) - TAB_W'(r_col[TAB_BITS-1:0]);
    assign w_idx_oor  = (i_item.cell_index >= CUR_W'(CELLS));
    assign w_idx_sat  = w_idx_oor ? CUR_W'(CELLS - 1) : i_item.cell_index;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_saddr == ADDR_W'(CELLS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (i_item.op)
                        OP_PUT: begin
                            if (i_item.char_code == CH_NEWLINE) begin
                                n_state = w_row_last ? ST_SCR_COPY : ST_CUR_RD;
                            end else begin
                                n_state = ST_PUT;
                            end
                        end
                        OP_READ:       n_state = ST_RD_DATA;
                        OP_SET_CURSOR: n_state = ST_DIV;
                        default:       n_state = ST_CUR_RD;
                    endcase
                end
            end
            ST_PUT: begin
                if (r_back)                    n_state = ST_CUR_RD;
                else if (w_put_wrap)           n_state = ST_SCR_COPY;
                else if (w_cnt_dec != '0)      n_state = ST_PUT;
                else                           n_state = ST_CUR_RD;
            end
            ST_DIV: begin
                if (r_divrem < CUR_W'(COLUMNS)) n_state = ST_CUR_RD;
            end
            ST_RD_DATA:   n_state = ST_CUR_RD;
            ST_SCR_COPY: begin
                if (r_saddr == ADDR_W'(CELLS - COLUMNS - 1)) n_state = ST_SCR_DRAIN;
            end
            ST_SCR_DRAIN: n_state = ST_SCR_BLANK;
            ST_SCR_BLANK: begin
                if (r_saddr == ADDR_W'(CELLS - 1)) begin
                    n_state = (r_cnt != '0) ? ST_PUT : ST_CUR_RD;
                end
            end
            ST_CUR_RD:    n_state = ST_CUR_WR;
            ST_CUR_WR:    n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Cursor, counters and captured fields
    always_comb begin
        n_cursor   = r_cursor;
        n_row      = r_row;
        n_col      = r_col;
        n_saddr    = r_saddr;
        n_wpend    = r_wpend;
        n_scrolled = r_scrolled;
        n_cnt      = r_cnt;
        n_back     = r_back;
        n_char     = r_char;
        n_rchar    = r_rchar;
        n_rattr    = r_rattr;
        n_oor      = r_oor;
        n_waddr    = r_waddr;
        n_divrem   = r_divrem;
        unique case (r_state)
            ST_CLEAR: n_saddr = r_saddr + ADDR_W'(1);
            ST_IDLE: begin
                if (w_accept) begin
                    n_scrolled = 1'b0;
                    n_rchar    = '0;
                    n_rattr    = '0;
                    n_back     = 1'b0;
                    n_cnt      = TAB_W'(1);
                    n_char     = i_item.char_code;
                    n_oor      = w_idx_oor;
                    unique case (i_item.op)
                        OP_PUT: begin
                            if (i_item.char_code == CH_NEWLINE) begin
                                n_cnt = '0;
                                if (w_row_last) begin
                                    // newline off the bottom row scrolls
                                    n_cursor   = CUR_W'(CELLS - COLUMNS);
                                    n_row      = ROW_W'(ROWS - 1);
                                    n_col      = '0;
                                    n_scrolled = 1'b1;
                                    n_saddr    = '0;
                                    n_wpend    = 1'b0;
                                end else begin
                                    n_row    = r_row + ROW_W'(1);
                                    n_col    = '0;
                                    n_cursor = r_cursor + CUR_W'(COLUMNS) - CUR_W'(r_col);
                                end
                            end else if (i_item.char_code == CH_TAB) begin
                                n_char = BLANK_CHAR;
                                n_cnt  = w_tab_n;
                            end else if (i_item.char_code == CH_BACKSPACE) begin
                                // step back (not below cell 0), then blank in place
                                n_char = BLANK_CHAR;
                                n_back = 1'b1;
                                if (r_cursor != '0) begin
                                    n_cursor = r_cursor - CUR_W'(1);
                                    if (r_col == '0) begin
                                        n_col = COL_W'(COLUMNS - 1);
                                        n_row = r_row - ROW_W'(1);
                                    end else begin
                                        n_col = r_col - COL_W'(1);
                                    end
                                end
                            end
                        end
                        OP_SET_CURSOR: begin
                            n_cursor = w_idx_sat;
                            n_divrem = w_idx_sat;
                            n_row    = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PUT: begin
                if (!r_back) begin
                    n_cnt = w_cnt_dec;
                    if (w_put_wrap) begin
                        n_cursor   = CUR_W'(CELLS - COLUMNS);
                        n_row      = ROW_W'(ROWS - 1);
                        n_col      = '0;
                        n_scrolled = 1'b1;
                        n_saddr    = '0;
                        n_wpend    = 1'b0;
                    end else if (w_col_last) begin
                        n_col    = '0;
                        n_row    = r_row + ROW_W'(1);
                        n_cursor = r_cursor + CUR_W'(1);
                    end else begin
                        n_col    = r_col + COL_W'(1);
                        n_cursor = r_cursor + CUR_W'(1);
                    end
                end
            end
            ST_DIV: begin
                // one row per cycle until the remainder is a column
                if (r_divrem >= CUR_W'(COLUMNS)) begin
                    n_divrem = r_divrem - CUR_W'(COLUMNS);
                    n_row    = r_row + ROW_W'(1);
                end else begin
                    n_col = r_divrem[COL_W-1:0];
                end
            end
            ST_RD_DATA: begin
                n_rchar = r_oor ? '0 : w_rdata[CHAR_W-1:0];
                n_rattr = r_oor ? '0 : w_rdata[CELL_W-1:CHAR_W];
            end
            ST_SCR_COPY: begin
                n_waddr = r_saddr;
                n_wpend = 1'b1;
                n_saddr = r_saddr + ADDR_W'(1);
            end
            ST_SCR_DRAIN: ;
            ST_SCR_BLANK: n_saddr = r_saddr + ADDR_W'(1);
            ST_CUR_RD:    ;
            ST_CUR_WR:    ;
            default:      ;
        endcase
    end

    // Store accesses
    always_comb begin
        w_wr.en   = 1'b0;
        w_wr.addr = ADDR_W'(r_cursor);
        w_wr.data = {r_attr, r_char};
        w_raddr   = ADDR_W'(r_cursor);
        unique case (r_state)
            ST_CLEAR: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_saddr;
                w_wr.data = {RESET_ATTR, BLANK_CHAR};
            end
            ST_IDLE: begin
                if (!w_idx_oor) w_raddr = ADDR_W'(i_item.cell_index);
            end
            ST_PUT: w_wr.en = 1'b1;
            ST_SCR_COPY: begin
                // read one row below, write the beat read last cycle
                w_raddr   = r_saddr + ADDR_W'(COLUMNS);
                w_wr.en   = r_wpend;
                w_wr.addr = r_waddr;
                w_wr.data = w_rdata;
            end
            ST_SCR_DRAIN: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_waddr;
                w_wr.data = w_rdata;
            end
            ST_SCR_BLANK: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_saddr;
                w_wr.data = {r_attr, BLANK_CHAR};
            end
            ST_CUR_WR: begin
                // cursor cell keeps its character, takes the attribute
                w_wr.en   = 1'b1;
                w_wr.data = {r_attr, w_rdata[CHAR_W-1:0]};
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cursor   <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_attr     <= RESET_ATTR;
            r_saddr    <= '0;
            r_wpend    <= 1'b0;
            r_scrolled <= 1'b0;
            r_cnt      <= '0;
            r_back     <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cursor   <= n_cursor;
            r_row      <= n_row;
            r_col      <= n_col;
            r_saddr    <= n_saddr;
            r_wpend    <= n_wpend;
            r_scrolled <= n_scrolled;
            r_cnt      <= n_cnt;
            r_back     <= n_back;
            r_strobe   <= (r_state == ST_CUR_WR);
            if (i_cfg_we) r_attr <= i_cfg_data;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_char   <= n_char;
        r_rchar  <= n_rchar;
        r_rattr  <= n_rattr;
        r_oor    <= n_oor;
        r_waddr  <= n_waddr;
        r_divrem <= n_divrem;
        if (r_state == ST_CUR_WR) begin
            r_res.cursor_cell <= r_cursor;
            r_res.read_char   <= r_rchar;
            r_res.read_attr   <= r_rattr;
            r_res.scrolled    <= r_scrolled;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

/* src/tccw_screen_ram.sv */
`timescale 1ns / 1ps
// Screen cell store: one write port, one read port, registered read data.
// Depends on tccw_pkg for the geometry and the write request type.
module tccw_screen_ram
    import tccw_pkg::*;
(
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tccw_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the text console character writer, bound to the top level.
// Depends on tccw_pkg and text_console_char_writer.
module tccw_checker
    import tccw_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    // An accepted command holds the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted beat");

    // One result beat per command, never two in a row
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // The result beat comes when the block is ready again
    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    // The reported cursor always lies on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.cursor_cell < CUR_W'(CELLS)))
        else $error("cursor beyond the last cell");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

/* tb/sv/text_console_char_writer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for text_console_char_writer: a short directed table, then random
// commands in three phases, beats checked against typed rows or a cycle-free screen model.
// Depends on tccw_pkg and the RTL of the block.
module text_console_char_writer_tb;
    import tccw_pkg::*;

    // The spare command code changes only the attribute under the cursor
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int IDX_MAX     = (1 << CUR_W) - 1;
    localparam int ITEMS_PHASE = 384;
    localparam int DRAIN_SLACK = 40;
    // Allow every beat to scroll, several times over
    localparam int CYCLE_LIMIT = 8_000_000;

    // One row of the directed table
    typedef struct packed {
        t_item   item;
        logic    typed;
        t_result want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_item             i_item;
    logic              i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_data;
    logic              o_strobe;
    t_result           o_result;

    // Screen model: attribute in the high byte, character in the low byte
    logic [CELL_W-1:0] screen_mem [0:CELLS-1];
    int                cursor_pos;
    logic [ATTR_W-1:0] text_attr;
    logic              scroll_seen;

    t_result pending_results [$];
    t_row    directed_rows [$];
    t_result typed_want;
    logic    typed_valid;
    int      accept_count;
    int      errors;
    int      cycle_count;

    text_console_char_writer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Scroll up one row once the cursor has run off the last cell
    function automatic void wrap_scroll();
        if (cursor_pos < CELLS)
            return;
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_mem[ADDR_W'(i)] = screen_mem[ADDR_W'(i + COLUMNS)];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_mem[ADDR_W'(i)] = {text_attr, BLANK_CHAR};
        cursor_pos  = CELLS - COLUMNS;
        scroll_seen = 1'b1;
    endfunction

    // Write one cell at the cursor and step on
    function automatic void put_cell(input logic [CHAR_W-1:0] ch);
        if (cursor_pos < CELLS)
            screen_mem[ADDR_W'(cursor_pos)] = {text_attr, ch};
        cursor_pos++;
        wrap_scroll();
    endfunction

    // Apply one command to the screen model and return the beat it gives
    function automatic t_result console_step(input t_item it);
        t_result r;
        int      n;
        r           = '0;
        scroll_seen = 1'b0;
        case (it.op)
            OP_PUT: begin
                if (it.char_code == CH_NEWLINE) begin
                    cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
                    wrap_scroll();
                end else if (it.char_code == CH_TAB) begin
                    n = TAB_STOP - ((cursor_pos % COLUMNS) & (TAB_STOP - 1));
                    repeat (n) put_cell(BLANK_CHAR);
                end else if (it.char_code == CH_BACKSPACE) begin
                    if (cursor_pos >= 1)
                        cursor_pos--;
                    put_cell(BLANK_CHAR);
                    cursor_pos--;
                end else begin
                    put_cell(it.char_code);
                end
            end
            OP_READ: begin
                if (it.cell_index < CELLS)
                    {r.read_attr, r.read_char} = screen_mem[it.cell_index];
            end
            OP_SET_CURSOR: begin
                cursor_pos = (it.cell_index < CELLS) ? int'(it.cell_index) : CELLS - 1;
            end
            default: ;
        endcase
        // cell under the cursor always takes the current attribute
        if (cursor_pos < CELLS)
            screen_mem[ADDR_W'(cursor_pos)][CELL_W-1:CHAR_W] = text_attr;
        r.cursor_cell = cursor_pos[CUR_W-1:0];
        r.scrolled    = scroll_seen;
        return r;
    endfunction

    function automatic t_row dir_row(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                     input int idx, input logic typed, input int cur,
                                     input logic [CHAR_W-1:0] rc, input logic [ATTR_W-1:0] ra,
                                     input logic sc);
        t_row r;
        r.item  = '{op, ch, idx[CUR_W-1:0]};
        r.typed = typed;
        r.want  = '{cur[CUR_W-1:0], rc, ra, sc};
        return r;
    endfunction

    // Random command, biased towards the screen end so that scrolls turn up often
    function automatic t_item draw_command();
        t_item it;
        int    pick;
        it.op         = OP_SPARE;
        it.char_code  = CHAR_W'($urandom_range(255));
        it.cell_index = CUR_W'($urandom_range(IDX_MAX));
        pick = $urandom_range(99);
        if (pick < 50) begin
            it.op = OP_PUT;
            pick  = $urandom_range(99);
            if (pick < 8)
                it.char_code = CH_NEWLINE;
            else if (pick < 14)
                it.char_code = CH_TAB;
            else if (pick < 20)
                it.char_code = CH_BACKSPACE;
        end else if (pick < 75) begin
            it.op = OP_READ;
            if ($urandom_range(9) != 0)
                it.cell_index = CUR_W'($urandom_range(CELLS - 1));
        end else if (pick < 93) begin
            it.op = OP_SET_CURSOR;
            if ($urandom_range(9) < 4)
                it.cell_index = CUR_W'($urandom_range(IDX_MAX, CELLS - 100));
        end
        return it;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input int want, input logic [15:0] got);
        if (got !== want[15:0])
            note_error($sformatf("%s mismatch, expected %0d, got %0d", name, want, got));
    endtask

    // Result beats are checked first, then a beat accepted at the same edge is predicted
    always @(posedge i_clk) begin : beat_monitor
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                got = o_result;
                if (pending_results.size() == 0) begin
                    note_error($sformatf("unexpected result beat, expected none, got %h", got));
                end else begin
                    want = pending_results.pop_front();
                    compare_field("cursor_cell", int'(want.cursor_cell),
                                  16'(got.cursor_cell));
                    compare_field("read_char", int'(want.read_char), 16'(got.read_char));
                    compare_field("read_attr", int'(want.read_attr), 16'(got.read_attr));
                    compare_field("scrolled", int'(want.scrolled), 16'(got.scrolled));
                end
            end
            if (start && !busy) begin
                want = console_step(i_item);
                if (typed_valid)
                    want = typed_want;
                pending_results.push_back(want);
                accept_count++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[text_console_char_writer] ERROR");
            $finish;
        end
    end

    // Present one command at a falling edge and hold it until accepted
    task automatic send_item(input t_item it, input int idle_pct);
        int seen;
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        seen   = accept_count;
        start  = 1'b1;
        i_item = it;
        do @(negedge i_clk); while (accept_count == seen);
    endtask

    // Stop sending and let every outstanding beat come back
    task automatic drain();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    task automatic set_attribute(input logic [ATTR_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        text_attr  = value;
    endtask

    initial begin
        int idle_pct;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        typed_valid  = 1'b0;
        typed_want   = '0;
        accept_count = 0;
        errors       = 0;
        cycle_count  = 0;
        cursor_pos   = 0;
        text_attr    = RESET_ATTR;
        for (int i = 0; i < CELLS; i++)
            screen_mem[ADDR_W'(i)] = {RESET_ATTR, BLANK_CHAR};

        // Directed table; typed rows carry their own expected beat
        directed_rows.push_back(dir_row(OP_READ, 8'h00, 0, 1, 0, BLANK_CHAR, RESET_ATTR, 0));
        directed_rows.push_back(dir_row(OP_READ, 8'h00, CELLS - 1, 1, 0, BLANK_CHAR,
                                        RESET_ATTR, 0));
        // read past the screen gives zeros
        directed_rows.push_back(dir_row(OP_READ, 8'hFF, IDX_MAX, 1, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, 8'h41, 0, 1, 1, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, 8'h00, IDX_MAX, 1, 2, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, 8'hFF, 0, 1, 3, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, CH_TAB, 0, 1, 8, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, CH_BACKSPACE, 0, 1, 7, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, CH_NEWLINE, 0, 1, COLUMNS, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_READ, 8'h00, 0, 0, 0, 0, 0, 0));
        // backspace at the top left stays put
        directed_rows.push_back(dir_row(OP_SET_CURSOR, 8'h00, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, CH_BACKSPACE, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_SPARE, 8'hFF, IDX_MAX, 1, 0, 0, 0, 0));
        // cursor set past the end saturates; next character scrolls
        directed_rows.push_back(dir_row(OP_SET_CURSOR, 8'h00, IDX_MAX, 1, CELLS - 1, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, 8'h5A, 0, 1, CELLS - COLUMNS, 0, 0, 1));
        directed_rows.push_back(dir_row(OP_READ, 8'h00, CELLS - COLUMNS - 1, 0, 0, 0, 0, 0));
        // newline on the bottom row scrolls
        directed_rows.push_back(dir_row(OP_SET_CURSOR, 8'h00, CELLS - 1, 1, CELLS - 1, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, CH_NEWLINE, 0, 1, CELLS - COLUMNS, 0, 0, 1));
        // tab running off the last cell scrolls
        directed_rows.push_back(dir_row(OP_SET_CURSOR, 8'h00, CELLS - 5, 1, CELLS - 5, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, CH_TAB, 0, 1, CELLS - COLUMNS, 0, 0, 1));
        directed_rows.push_back(dir_row(OP_SET_CURSOR, 8'h00, CELLS - 1, 1, CELLS - 1, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_PUT, CH_BACKSPACE, 0, 1, CELLS - 2, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_READ, 8'h00, CELLS - 2, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_SET_CURSOR, 8'h00, 1024, 1, 1024, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_READ, 8'h00, 1024, 0, 0, 0, 0, 0));

        // Synchronous reset, released at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            typed_valid = directed_rows[k].typed;
            typed_want  = directed_rows[k].want;
            send_item(directed_rows[k].item, 0);
        end
        typed_valid = 1'b0;

        // Random phases: attribute extremes first, then a random one; sender gaps widen, then vanish
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            case (ph)
                0: set_attribute(8'h00);
                1: set_attribute(8'hFF);
                default: set_attribute(ATTR_W'($urandom_range(254, 1)));
            endcase
            idle_pct = (ph == 0) ? 37 : (ph == 1) ? 68 : 0;
            repeat (ITEMS_PHASE) send_item(draw_command(), idle_pct);
        end
        drain();

        if (errors == 0)
            $display("[text_console_char_writer] OK");
        else
            $display("[text_console_char_writer] ERROR");
        $finish;
    end

endmodule
